// ===== hw/rtl/iit_pkg.sv =====
// ----------------------------------------------------------------------------
// iit_pkg
// shared types and constants of the interpolated input table
// ----------------------------------------------------------------------------
package iit_pkg;

    localparam int CHANNELS   = 4;
    localparam int ENTRIES    = 256;
    localparam int CH_W       = 2;
    localparam int IDX_W      = 8;
    localparam int LEN_W      = 9;
    localparam int ADDR_W     = CH_W + IDX_W;
    localparam int DEPTH      = CHANNELS * ENTRIES;
    localparam int DATA_W     = 32;
    localparam int QUOT_W     = 66;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_LEN   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_EXACT  = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_LEN, OP_START, OP_RD, OP_CHECK,
        OP_SCAN, OP_PAIR, OP_SETUP, OP_MUL, OP_DIV, OP_FIN
    } op_t;

    typedef struct packed {
        op_t op;
    } iit_cmd_t;

    typedef struct packed {
        logic done;     // early result, scan finished or pair read finished
        logic early;    // result already formed
        logic div_done;
    } iit_sts_t;

endpackage

// ===== hw/rtl/iit_ram.sv =====
// ----------------------------------------------------------------------------
// iit_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module iit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/iit_datapath.sv =====
// ----------------------------------------------------------------------------
// iit_datapath
// tables, segment scan, multiplier and restoring divider
// ----------------------------------------------------------------------------
module iit_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  iit_pkg::iit_cmd_t           cmd,
    output iit_pkg::iit_sts_t           sts,
    input  logic signed [1:0]           direction,
    input  logic [1:0]                  in_mode,
    input  logic [1:0]                  in_channel,
    input  logic [7:0]                  in_entry_index,
    input  logic signed [31:0]          in_time_point,
    input  logic signed [31:0]          in_sample_value,
    input  logic [8:0]                  in_table_length,
    output logic signed [31:0]          res_value,
    output logic [1:0]                  res_status,
    output logic [7:0]                  res_segment
);
    import iit_pkg::*;

    logic [LEN_W-1:0] len_reg [CHANNELS];
    logic [IDX_W-1:0] cache_reg [CHANNELS];

    logic [CH_W-1:0]   ch_reg;
    logic signed [31:0] t_reg;
    logic              asc_reg;
    logic [LEN_W-1:0]  qlen_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic              fwd_reg;
    logic              first_reg;
    logic signed [31:0] tfirst_reg, t0_reg, v0_reg;
    logic [1:0]        phase_reg;
    logic [IDX_W-1:0]  seg_reg;
    logic [2:0]        rdstep_reg;
    logic signed [32:0] dv_reg, off_reg, dt_reg;
    logic              neg_reg;
    logic [65:0]       prod_reg;
    logic [65:0]       quo_reg;
    logic [33:0]       rem_reg;
    logic [6:0]        cnt_reg;

    logic              we;
    logic              ch_ok;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       t_rd, v_rd;
    logic [IDX_W-1:0]  rd_idx;

    assign ch_ok = {1'b0, in_channel} < (CH_W+1)'(CHANNELS);
    assign we = (cmd.op == OP_LOAD) && ch_ok;
    assign addr = (cmd.op == OP_LOAD) ? {in_channel, in_entry_index} : {ch_reg, rd_idx};

    iit_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_time (
        .aclk(aclk), .we(we), .addr(addr), .wdata(in_time_point), .rdata(t_rd));
    iit_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_value (
        .aclk(aclk), .we(we), .addr(addr), .wdata(in_sample_value), .rdata(v_rd));

    // read address per step
    logic [IDX_W-1:0] last_idx;
    assign last_idx = IDX_W'(qlen_reg - 1'b1);
    always_comb begin
        rd_idx = cur_reg;
        case (cmd.op)
            OP_RD:    rd_idx = (phase_reg == 2'd0) ? '0 :
                               (phase_reg == 2'd1) ? last_idx : cur_reg;
            OP_PAIR:  rd_idx = (rdstep_reg == 3'd2) ? IDX_W'(seg_reg + 1'b1) : seg_reg;
            default:  rd_idx = cur_reg;
        endcase
    end

    logic signed [31:0] tr, vr;
    assign tr = t_rd;
    assign vr = v_rd;
    logic hit_fwd, hit_bwd;
    assign hit_fwd = asc_reg ? (tr >= t_reg) : (tr < t_reg);
    assign hit_bwd = asc_reg ? (tr < t_reg) : (tr >= t_reg);

    logic [34:0] rsh;
    assign rsh = {rem_reg, prod_reg[65]};
    logic [33:0] dabs;
    assign dabs = dt_reg[32] ? 34'(-dt_reg) : 34'(dt_reg);

    function automatic logic signed [31:0] sat_sum(
        input logic signed [31:0] v0, input logic [65:0] q, input logic neg);
        logic [41:0] qm;
        logic signed [43:0] s;
        begin
            qm = (q > 66'(42'd1 << 40)) ? (42'd1 << 40) : q[41:0];
            s = 44'(v0) + (neg ? -44'(qm) : 44'(qm));
            if (s > 44'sd2147483647) sat_sum = 32'sh7fffffff;
            else if (s < -44'sd2147483648) sat_sum = 32'sh80000000;
            else sat_sum = s[31:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        iit_sts_t sts_next;
        sts_next = '0;
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                len_reg[i]   <= '0;
                cache_reg[i] <= '0;
            end
            sts <= '0;
        end else begin
            case (cmd.op)
                OP_LOAD: ;
                OP_LEN: begin
                    if (ch_ok) begin
                        len_reg[in_channel] <= (in_table_length > LEN_W'(ENTRIES)) ?
                                               LEN_W'(ENTRIES) : in_table_length;
                    end
                end
                OP_START: begin
                    ch_reg    <= in_channel;
                    t_reg     <= in_time_point;
                    asc_reg   <= ~direction[1];
                    phase_reg <= 2'd0;
                    res_value <= '0;
                    res_segment <= '0;
                    if (!ch_ok || len_reg[in_channel] == '0) begin
                        res_status <= ST_EMPTY;
                        sts_next.done = 1'b1;
                        sts_next.early = 1'b1;
                    end
                    qlen_reg <= len_reg[in_channel];
                    cur_reg <= (cache_reg[in_channel] >= len_reg[in_channel]) ?
                               IDX_W'(len_reg[in_channel] - 1'b1) : cache_reg[in_channel];
                end
                OP_RD: ;
                OP_CHECK: begin
                    // phase 0 first, 1 last, 2 cached
                    if (phase_reg == 2'd0) begin
                        tfirst_reg <= tr;
                        if (qlen_reg == LEN_W'(1) && tr == t_reg) begin
                            res_value <= vr; res_status <= ST_EXACT;
                            sts_next.done = 1'b1; sts_next.early = 1'b1;
                        end else if (direction == 2'sd0) begin
                            res_status <= ST_EMPTY;
                            sts_next.done = 1'b1; sts_next.early = 1'b1;
                        end
                        phase_reg <= 2'd1;
                    end else if (phase_reg == 2'd1) begin
                        if (asc_reg ? (t_reg < tfirst_reg || t_reg > tr)
                                    : (t_reg > tfirst_reg || t_reg < tr)) begin
                            res_status <= ST_RANGE;
                            sts_next.done = 1'b1; sts_next.early = 1'b1;
                        end
                        phase_reg <= 2'd2;
                    end else begin
                        fwd_reg <= asc_reg ? (tr < t_reg) : (tr >= t_reg);
                        first_reg <= 1'b1;
                        seg_reg <= '0;
                        phase_reg <= 2'd3;
                    end
                end
                OP_SCAN: begin
                    // tr is entry cur_reg
                    first_reg <= 1'b0;
                    if (fwd_reg) begin
                        if (!first_reg && hit_fwd) begin
                            seg_reg <= IDX_W'(cur_reg - 1'b1);
                            sts_next.done = 1'b1;
                        end else if (first_reg && hit_fwd) begin
                            seg_reg <= IDX_W'(cur_reg - 1'b1);
                            sts_next.done = 1'b1;
                        end else if (LEN_W'(cur_reg) + 1'b1 >= qlen_reg) begin
                            seg_reg <= '0;
                            sts_next.done = 1'b1;
                        end else begin
                            cur_reg <= cur_reg + 1'b1;
                        end
                    end else begin
                        if (hit_bwd) begin
                            seg_reg <= cur_reg;
                            sts_next.done = 1'b1;
                        end else if (cur_reg == '0) begin
                            seg_reg <= '0;
                            sts_next.done = 1'b1;
                        end else begin
                            cur_reg <= cur_reg - 1'b1;
                        end
                    end
                    rdstep_reg <= '0;
                end
                OP_PAIR: begin
                    if (rdstep_reg == 3'd0) begin
                        if (LEN_W'(seg_reg) > qlen_reg - LEN_W'(2)) begin
                            seg_reg <= IDX_W'(qlen_reg - LEN_W'(2));
                        end
                        rdstep_reg <= 3'd1;
                    end else if (rdstep_reg == 3'd1) begin
                        cache_reg[ch_reg] <= seg_reg;
                        rdstep_reg <= 3'd2;
                    end else if (rdstep_reg == 3'd2) begin
                        t0_reg <= tr; v0_reg <= vr;
                        rdstep_reg <= 3'd3;
                    end else begin
                        res_segment <= seg_reg;
                        if (tr == t_reg) begin
                            res_value <= vr; res_status <= ST_EXACT;
                            sts_next.done = 1'b1; sts_next.early = 1'b1;
                        end else if (t_reg == t0_reg) begin
                            res_value <= v0_reg; res_status <= ST_EXACT;
                            sts_next.done = 1'b1; sts_next.early = 1'b1;
                        end else if (tr == t0_reg) begin
                            res_value <= v0_reg; res_status <= ST_INTERP;
                            sts_next.done = 1'b1; sts_next.early = 1'b1;
                        end else begin
                            dv_reg  <= 33'(vr) - 33'(v0_reg);
                            off_reg <= 33'(t_reg) - 33'(t0_reg);
                            dt_reg  <= 33'(tr) - 33'(t0_reg);
                            sts_next.done = 1'b1;
                        end
                    end
                end
                OP_MUL: begin
                    prod_reg <= 66'((dv_reg[32] ? 33'(-dv_reg) : dv_reg)) *
                                66'((off_reg[32] ? 33'(-off_reg) : off_reg));
                    neg_reg  <= dv_reg[32] ^ off_reg[32] ^ dt_reg[32];
                    rem_reg  <= '0;
                    cnt_reg  <= '0;
                    res_status <= ST_INTERP;
                end
                OP_DIV: begin
                    // one quotient bit per cycle
                    if (35'(rsh) >= 35'(dabs)) begin
                        rem_reg <= 34'(rsh - 35'(dabs));
                        quo_reg <= {quo_reg[64:0], 1'b1};
                    end else begin
                        rem_reg <= rsh[33:0];
                        quo_reg <= {quo_reg[64:0], 1'b0};
                    end
                    prod_reg <= {prod_reg[64:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 7'd65) sts_next.div_done = 1'b1;
                end
                OP_FIN: begin
                    res_value <= sat_sum(v0_reg, quo_reg, neg_reg);
                end
                default: ;
            endcase
            if (cmd.op == OP_SETUP) quo_reg <= '0;
            sts <= sts_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_LOAD |-> in_mode == MODE_LOAD) else $error("load op mismatch");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_DIV |-> cnt_reg <= 7'd65) else $error("divider overrun");
    assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> $past(cmd.op) == OP_DIV) else $error("stray divide done");
endmodule

// ===== hw/rtl/iit_ctrl.sv =====
// ----------------------------------------------------------------------------
// iit_ctrl
// sequencer for load, length and query transfers
// ----------------------------------------------------------------------------
module iit_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    output logic              m_valid,
    input  logic              m_ready,
    output iit_pkg::iit_cmd_t cmd,
    input  iit_pkg::iit_sts_t sts
);
    import iit_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_START = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_CHECK = 10'b0000001000,
        S_SCAN  = 10'b0000010000,
        S_PAIR  = 10'b0000100000,
        S_MUL   = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic acc;
    assign s_ready = (state_reg == S_IDLE);
    assign acc = s_valid && s_ready;
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    case (s_mode)
                        MODE_LOAD:  cmd.op = OP_LOAD;
                        MODE_LEN:   cmd.op = OP_LEN;
                        MODE_QUERY: begin
                            cmd.op = OP_START;
                            state_next = S_START;
                            cnt_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_START: begin
                // sts from start or check visible here
                if (sts.done) state_next = S_OUT;
                else begin cmd.op = OP_RD; state_next = S_RD; end
            end
            S_RD: begin cmd.op = OP_RD; state_next = S_CHECK; end
            S_CHECK: begin
                cmd.op = OP_CHECK;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd2) state_next = S_SCAN;
                else state_next = S_START;
            end
            S_SCAN: begin
                if (sts.done) begin
                    if (sts.early) state_next = S_OUT;
                    else begin cmd.op = OP_PAIR; state_next = S_PAIR; cnt_next = '0; end
                end else if (cnt_reg[0]) begin
                    cmd.op = OP_SCAN; cnt_next = '0;
                end else begin
                    cnt_next = 3'd1;
                end
            end
            S_PAIR: begin
                cmd.op = OP_PAIR;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd2) state_next = S_MUL;
            end
            S_MUL: begin
                if (sts.done) begin
                    if (sts.early) state_next = S_OUT;
                    else begin cmd.op = OP_MUL; state_next = S_DIV; end
                end else cmd.op = OP_SETUP;
            end
            S_DIV: begin
                if (sts.div_done) begin cmd.op = OP_FIN; state_next = S_FIN; end
                else cmd.op = OP_DIV;
            end
            S_FIN: state_next = S_OUT;
            S_OUT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("accepting while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_DIV) |-> state_reg == S_DIV) else $error("divide outside state");
endmodule

// ===== hw/rtl/interpolated_input_table_unit.sv =====
// ----------------------------------------------------------------------------
// interpolated_input_table_unit
// per-channel piecewise linear interpolation tables, signed q16.16
// ----------------------------------------------------------------------------
// channel  | ports                                   | handshake
// input    | s_mode s_channel s_entry_index ...      | s_valid / s_ready
// result   | m_value m_status m_segment_index        | m_valid / m_ready
// config   | cfg_we cfg_wdata                        | write enable only
//
// loads and length updates leave the unit ready for the next transfer; a query reads
// the first, last and cached entries, scans from the cached segment, reads the pair
// and interpolates with a multiply and a one quotient bit per cycle divider; empty,
// single entry or disabled and out of range results end the query early
// one query in flight; input stalls until the result transfer completes
// reset clears lengths and cached segments; breakpoint memories are not cleared
module interpolated_input_table_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [1:0]         s_channel,
    input  logic [7:0]         s_entry_index,
    input  logic signed [31:0] s_time_point,
    input  logic signed [31:0] s_sample_value,
    input  logic [8:0]         s_table_length,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value,
    output logic [1:0]         m_status,
    output logic [7:0]         m_segment_index,
    input  logic               cfg_we,
    input  logic signed [1:0]  cfg_wdata
);
    import iit_pkg::*;

    logic signed [1:0] direction_reg;
    iit_cmd_t cmd;
    iit_sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 2'sd1;
        end else if (cfg_we) begin
            direction_reg <= cfg_wdata;
        end
    end

    iit_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_mode(s_mode), .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .sts(sts));

    iit_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts), .direction(direction_reg),
        .in_mode(s_mode), .in_channel(s_channel), .in_entry_index(s_entry_index),
        .in_time_point(s_time_point), .in_sample_value(s_sample_value),
        .in_table_length(s_table_length), .res_value(m_value), .res_status(m_status),
        .res_segment(m_segment_index));
endmodule
